### sv/qe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qe_pkg
// Shared types and constants of the quartile engine.
// ----------------------------------------------------------------------------
package qe_pkg;

	localparam int MAX_SAMPLES_DEF = 256;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int OUT_BITS        = 18;

	// set size modulo four, selects the interpolation rule
	localparam logic [1:0] RES_ZERO  = 2'd0;
	localparam logic [1:0] RES_ONE   = 2'd1;
	localparam logic [1:0] RES_TWO   = 2'd2;
	localparam logic [1:0] RES_THREE = 2'd3;

	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_DRAIN = 3'b010,
		ST_CALC  = 3'b100
	} state_t;

endpackage

### sv/qe_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qe_cell
// One slot of the insertion sorter: holds a sample, inserts a broadcast word
// in order by taking its left neighbor, or shifts toward slot zero on drain.
// ----------------------------------------------------------------------------
module qe_cell #(
	parameter int SAMPLE_BITS = qe_pkg::SAMPLE_BITS_DEF,
	parameter int CW          = 9,
	parameter int INDEX       = 0
) (
	input  logic                          clk,
	input  qe_pkg::cell_ctrl_t            ctrl,
	input  logic [CW-1:0]                 count,
	input  logic signed [SAMPLE_BITS-1:0] din,
	input  logic signed [SAMPLE_BITS-1:0] left_val,
	input  logic                          left_gt,
	input  logic signed [SAMPLE_BITS-1:0] right_val,
	output logic signed [SAMPLE_BITS-1:0] val,
	output logic                          gt
);

	localparam logic [CW-1:0] IDX = CW'(INDEX);

	logic signed [SAMPLE_BITS-1:0] val_q;

	// empty slots count as greater so the word lands at the end
	assign gt  = (IDX >= count) || (val_q > din);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			val_q <= right_val;
		end else if (ctrl.insert && gt) begin
			val_q <= left_gt ? left_val : din;
		end
	end

endmodule

### sv/quartile_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quartile_engine_top
// Samples of a set enter a row of MAX_SAMPLES sorter cells one word per
// cycle while ready is high, and are kept in ascending order. The word
// marked last closes the set: the row then shifts its stored samples out
// toward cell zero while the six samples the quartile rules need are
// caught, and the calculation state weighs them into q1, q2 and q3 (times
// four). No word is taken until drain and calculation are through. A
// closing word also waits while the previous result is untaken. Samples
// beyond MAX_SAMPLES are dropped and reported on overflowed.
// ----------------------------------------------------------------------------
module quartile_engine_top #(
	parameter int MAX_SAMPLES = qe_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = qe_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 valid,
	output logic                                 ready,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	input  logic                                 last,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic signed [qe_pkg::OUT_BITS-1:0]   q1,
	output logic signed [qe_pkg::OUT_BITS-1:0]   q2,
	output logic signed [qe_pkg::OUT_BITS-1:0]   q3,
	output logic                                 overflowed
);

	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int SW = SAMPLE_BITS + 3;
	localparam logic [CW-1:0] FULL = CW'(MAX_SAMPLES);
	localparam logic [CW-1:0] ONE  = CW'(1);

	qe_pkg::state_t     st_q;
	qe_pkg::cell_ctrl_t ctrl;

	logic [CW-1:0] count_q;
	logic          drop_q;
	logic          ovf_q;
	logic          result_valid_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] k_q;

	logic          accept;
	logic          store_ok;
	logic [CW-1:0] n_close;
	logic [CW+1:0] n3;
	logic [CW-1:0] b_idx, m_idx, a_idx;

	logic [CW-1:0] lo_d [3];
	logic [CW-1:0] hi_d [3];
	logic [1:0]    wlo_d [3];
	logic [1:0]    whi_d [3];
	logic [CW-1:0] lo_q [3];
	logic [CW-1:0] hi_q [3];
	logic [1:0]    wlo_q [3];
	logic [1:0]    whi_q [3];

	logic signed [SAMPLE_BITS-1:0] lo_v_q [3];
	logic signed [SAMPLE_BITS-1:0] hi_v_q [3];
	logic signed [SW-1:0]          qsum [3];

	logic signed [SAMPLE_BITS-1:0] cell_val [MAX_SAMPLES];
	logic                          cell_gt  [MAX_SAMPLES];

	assign ready        = (st_q == qe_pkg::ST_LOAD) && !(result_valid_q && last);
	assign accept       = valid && ready;
	assign store_ok     = (count_q != FULL);
	assign result_valid = result_valid_q;

	assign ctrl.insert = accept && store_ok;
	assign ctrl.shift  = (st_q == qe_pkg::ST_DRAIN);

	// sorter row
	for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] lv;
		logic                          lg;
		logic signed [SAMPLE_BITS-1:0] rv;
		if (i == 0) begin : g_first
			assign lv = '0;
			assign lg = 1'b0;
		end else begin : g_mid
			assign lv = cell_val[i-1];
			assign lg = cell_gt[i-1];
		end
		if (i == MAX_SAMPLES - 1) begin : g_end
			assign rv = cell_val[i];
		end else begin : g_inner
			assign rv = cell_val[i+1];
		end
		qe_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.CW         (CW),
			.INDEX      (i)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.count    (count_q),
			.din      (sample),
			.left_val (lv),
			.left_gt  (lg),
			.right_val(rv),
			.val      (cell_val[i]),
			.gt       (cell_gt[i])
		);
	end

	// quartile indices and weights for the closing set
	assign n_close = store_ok ? count_q + ONE : count_q;
	assign n3      = ({2'b00, n_close} << 1) + {2'b00, n_close};
	assign b_idx   = n_close >> 2;
	assign m_idx   = n_close >> 1;
	assign a_idx   = n3[CW+1:2];

	always_comb begin
		case (n_close[1:0])
			qe_pkg::RES_THREE: begin
				lo_d[0] = b_idx;       hi_d[0] = b_idx + ONE; wlo_d[0] = 2'd2; whi_d[0] = 2'd2;
				lo_d[1] = m_idx;       hi_d[1] = m_idx;       wlo_d[1] = 2'd2; whi_d[1] = 2'd2;
				lo_d[2] = a_idx - ONE; hi_d[2] = a_idx;       wlo_d[2] = 2'd2; whi_d[2] = 2'd2;
			end
			qe_pkg::RES_ONE: begin
				lo_d[0] = b_idx;       hi_d[0] = b_idx;       wlo_d[0] = 2'd2; whi_d[0] = 2'd2;
				lo_d[1] = m_idx;       hi_d[1] = m_idx;       wlo_d[1] = 2'd2; whi_d[1] = 2'd2;
				lo_d[2] = a_idx;       hi_d[2] = a_idx;       wlo_d[2] = 2'd2; whi_d[2] = 2'd2;
			end
			qe_pkg::RES_TWO: begin
				lo_d[0] = b_idx;       hi_d[0] = b_idx + ONE; wlo_d[0] = 2'd3; whi_d[0] = 2'd1;
				lo_d[1] = m_idx - ONE; hi_d[1] = m_idx;       wlo_d[1] = 2'd2; whi_d[1] = 2'd2;
				lo_d[2] = a_idx - ONE; hi_d[2] = a_idx;       wlo_d[2] = 2'd1; whi_d[2] = 2'd3;
			end
			default: begin
				lo_d[0] = b_idx - ONE; hi_d[0] = b_idx;       wlo_d[0] = 2'd1; whi_d[0] = 2'd3;
				lo_d[1] = m_idx - ONE; hi_d[1] = m_idx;       wlo_d[1] = 2'd2; whi_d[1] = 2'd2;
				lo_d[2] = a_idx - ONE; hi_d[2] = a_idx;       wlo_d[2] = 2'd3; whi_d[2] = 2'd1;
			end
		endcase
	end

	// weighted pair sums, weights 1 to 3
	always_comb begin
		logic signed [SW-1:0] el;
		logic signed [SW-1:0] eh;
		logic signed [SW-1:0] tl;
		logic signed [SW-1:0] th;
		for (int j = 0; j < 3; j++) begin
			el = SW'(lo_v_q[j]);
			eh = SW'(hi_v_q[j]);
			tl = (wlo_q[j][1] ? (el <<< 1) : SW'(0)) + (wlo_q[j][0] ? el : SW'(0));
			th = (whi_q[j][1] ? (eh <<< 1) : SW'(0)) + (whi_q[j][0] ? eh : SW'(0));
			qsum[j] = tl + th;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= qe_pkg::ST_LOAD;
			count_q        <= '0;
			drop_q         <= 1'b0;
			ovf_q          <= 1'b0;
			result_valid_q <= 1'b0;
			n_q            <= '0;
			k_q            <= '0;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (st_q)
				qe_pkg::ST_LOAD: begin
					if (accept) begin
						if (last) begin
							count_q <= '0;
							drop_q  <= 1'b0;
							ovf_q   <= drop_q || !store_ok;
							n_q     <= n_close;
							k_q     <= '0;
							st_q    <= qe_pkg::ST_DRAIN;
						end else if (store_ok) begin
							count_q <= count_q + ONE;
						end else begin
							drop_q <= 1'b1;
						end
					end
				end
				qe_pkg::ST_DRAIN: begin
					k_q <= k_q + ONE;
					if (k_q == n_q - ONE) begin
						st_q <= qe_pkg::ST_CALC;
					end
				end
				qe_pkg::ST_CALC: begin
					result_valid_q <= 1'b1;
					st_q           <= qe_pkg::ST_LOAD;
				end
				default: begin
					st_q <= qe_pkg::ST_LOAD;
				end
			endcase
		end
	end

	// index registers, drain capture and result words
	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			if (accept && last) begin
				lo_q[j]  <= lo_d[j];
				hi_q[j]  <= hi_d[j];
				wlo_q[j] <= wlo_d[j];
				whi_q[j] <= whi_d[j];
			end
			if (st_q == qe_pkg::ST_DRAIN) begin
				if (k_q == lo_q[j]) begin
					lo_v_q[j] <= cell_val[0];
				end
				if (k_q == hi_q[j]) begin
					hi_v_q[j] <= cell_val[0];
				end
			end
		end
		if (st_q == qe_pkg::ST_CALC) begin
			q1         <= qe_pkg::OUT_BITS'(qsum[0]);
			q2         <= qe_pkg::OUT_BITS'(qsum[1]);
			q3         <= qe_pkg::OUT_BITS'(qsum[2]);
			overflowed <= ovf_q;
		end
	end

endmodule

### sv/quartile_engine_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quartile_engine_chk
// Port-level checks of the quartile engine, bound to the top level.
// ----------------------------------------------------------------------------
module quartile_engine_chk #(
	parameter int SAMPLE_BITS = qe_pkg::SAMPLE_BITS_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               valid,
	input logic                               ready,
	input logic signed [SAMPLE_BITS-1:0]      sample,
	input logic                               last,
	input logic                               result_valid,
	input logic                               result_ready,
	input logic signed [qe_pkg::OUT_BITS-1:0] q1,
	input logic signed [qe_pkg::OUT_BITS-1:0] q2,
	input logic signed [qe_pkg::OUT_BITS-1:0] q3,
	input logic                               overflowed
);

	// result word holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(q1) && $stable(q2)
			&& $stable(q3) && $stable(overflowed))
		else $error("result word changed while stalled");

	// closing word starts the drain, input is held off
	a_close_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ready && last |=> !ready)
		else $error("input taken during drain");

	// a new result only follows a closed set
	a_result_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!ready))
		else $error("result without drain");

	// quartiles are ordered when no wrap is possible
	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (SAMPLE_BITS <= 16) |-> (q1 <= q2) && (q2 <= q3))
		else $error("quartiles out of order");

endmodule

bind quartile_engine_top quartile_engine_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (.*);
